### hw/rtl/kapc_pkg.sv
`timescale 1ns / 1ps

package kapc_pkg;

  localparam int unsigned MAX_CODE_DIGITS_DEF = 12;
  localparam int unsigned PASSCODE_W          = 48;
  localparam int unsigned CODE_LEN_W          = 4;
  localparam int unsigned DELAY_W             = 16;
  localparam int unsigned CFG_DATA_W          = 48;
  localparam int unsigned KEY_W               = 5;
  localparam int unsigned SENSOR_W            = 4;
  localparam int unsigned DIGIT_W             = 4;
  localparam int unsigned IN_DATA_W           = 16;
  localparam int unsigned OUT_DATA_W          = 16;

  localparam logic [PASSCODE_W-1:0] PASSCODE_RST = 48'h0973_1ADA_BACA;
  localparam logic [CODE_LEN_W-1:0] CODE_LEN_RST = 4'd11;
  localparam logic [DELAY_W-1:0]    DELAY_RST    = 16'd5120;

  localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
  localparam logic [KEY_W-1:0] KEY_STAR = 5'd15;
  localparam logic [KEY_W-1:0] KEY_HASH = 5'd16;

  typedef enum logic [1:0] {
    REG_PASSCODE  = 2'd0,
    REG_CODE_LEN  = 2'd1,
    REG_ARM_DELAY = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_DISARMED     = 3'd0,
    MODE_ARM_ENTRY    = 3'd1,
    MODE_DELAY        = 3'd2,
    MODE_ARMED        = 3'd3,
    MODE_ALARM        = 3'd4,
    MODE_DISARM_ENTRY = 3'd5,
    MODE_WRONG        = 3'd6
  } mode_t;

endpackage

### hw/rtl/keypad_alarm_panel_controller.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Payload
// in_      | in  | in_tvalid / in_tready   | in_tdata: key_code, sensor_levels, timer_tick
// out_     | out | out_tvalid / out_tready | out_tdata: lamps, buzzer, mode, echo, tripped mask
// cfg_     | in  | cfg_wr_en (no wait)     | cfg_index, cfg_wdata
// One beat per cycle: the panel state updates on the accepting edge and the
// result is pushed into a two-entry output queue, visible the next cycle.
// in_tready drops only while both queue entries are full.
// rst_n is synchronous: mode disarmed, no previous key, empty entry, queue empty,
// registers back to their defaults.
module keypad_alarm_panel_controller
  import kapc_pkg::*;
#(
  parameter int unsigned MAX_CODE_DIGITS = MAX_CODE_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [4:0] key_code, [8:5] sensor_levels, [9] timer_tick, [15:10] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] red_lamp, [1] green_lamp, [2] yellow_lamp, [3] buzzer_on,
  // [6:4] panel_mode, [7] digit_echo, [11:8] tripped_mask, [15:12] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CW   = $clog2(MAX_CODE_DIGITS + 1);
  localparam int unsigned IW   = $clog2(MAX_CODE_DIGITS);
  localparam int unsigned LW   = (CW > CODE_LEN_W) ? CW : CODE_LEN_W;
  localparam int unsigned DW   = MAX_CODE_DIGITS * DIGIT_W;
  localparam int unsigned EXTW = (DW > PASSCODE_W) ? DW : PASSCODE_W;

  logic [PASSCODE_W-1:0] passcode_r;
  logic [CODE_LEN_W-1:0] code_len_r;
  logic [DELAY_W-1:0]    arm_delay_r;

  mode_t             mode_r, mode_nxt;
  logic [KEY_W-1:0]  prev_key_r;
  logic [DIGIT_W-1:0] digits_r [MAX_CODE_DIGITS];
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;

  logic [OUT_DATA_W-1:0] q_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            q_cnt_r;

  logic                in_fire, out_fire;
  logic [KEY_W-1:0]    key;
  logic [SENSOR_W-1:0] sensors;
  logic                tick;
  logic                released, rel_hash, rel_code, store_en, echo;
  logic                match, digits_ok;
  logic [EXTW-1:0]     pass_wide;
  logic [DELAY_W-1:0]  delay_inc;
  logic                red, green, yellow;
  logic [SENSOR_W-1:0] tripped;
  logic [OUT_DATA_W-1:0] result;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign key      = in_tdata[4:0];
  assign sensors  = in_tdata[8:5];
  assign tick     = in_tdata[9];

  assign released  = (key == KEY_NONE) && (prev_key_r != KEY_NONE);
  assign rel_hash  = released && (prev_key_r == KEY_HASH);
  assign rel_code  = released && (prev_key_r >= 5'd1) && (prev_key_r <= KEY_STAR);
  assign pass_wide = EXTW'(passcode_r);
  assign delay_inc = delay_r + 16'd1;

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
      if ((CW'(i) < count_r) && (digits_r[i] != pass_wide[DIGIT_W*i +: DIGIT_W])) begin
        digits_ok = 1'b0;
      end
    end
    match = !ovf_r && (LW'(count_r) == LW'(code_len_r)) && digits_ok;
  end

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    delay_nxt = delay_r;
    store_en  = 1'b0;
    echo      = 1'b0;
    case (mode_r)
      MODE_DISARMED: begin
        if (released && (prev_key_r == KEY_STAR)) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          mode_nxt  = MODE_ARM_ENTRY;
        end
      end
      MODE_ARM_ENTRY, MODE_DISARM_ENTRY: begin
        if (rel_hash) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          if (match) begin
            delay_nxt = (mode_r == MODE_ARM_ENTRY) ? '0 : delay_r;
            mode_nxt  = (mode_r == MODE_ARM_ENTRY) ? MODE_DELAY : MODE_DISARMED;
          end else begin
            mode_nxt = (mode_r == MODE_ARM_ENTRY) ? MODE_WRONG : MODE_DISARM_ENTRY;
          end
        end else if (rel_code) begin
          echo = 1'b1;
          if (count_r < CW'(MAX_CODE_DIGITS)) begin
            store_en  = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      MODE_DELAY: begin
        if (tick) begin
          if (delay_inc >= arm_delay_r) begin
            delay_nxt = '0;
            mode_nxt  = MODE_ARMED;
          end else begin
            delay_nxt = delay_inc;
          end
        end
      end
      MODE_ARMED: begin
        if (sensors != 4'hF) begin
          mode_nxt = MODE_ALARM;
        end
      end
      MODE_ALARM, MODE_WRONG: begin
        if (rel_hash) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          mode_nxt  = (mode_r == MODE_ALARM) ? MODE_DISARM_ENTRY : MODE_ARM_ENTRY;
        end
      end
      default: begin
        mode_nxt = MODE_DISARMED;
      end
    endcase
  end

  always_comb begin
    red     = mode_nxt inside {MODE_ALARM, MODE_DISARM_ENTRY};
    green   = mode_nxt inside {MODE_DISARMED, MODE_ARM_ENTRY, MODE_WRONG};
    yellow  = mode_nxt inside {MODE_DELAY, MODE_ARMED};
    tripped = (mode_nxt == MODE_ALARM) ? ~sensors : '0;
    result  = {4'd0, tripped, echo, mode_nxt, red, yellow, green, red};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passcode_r  <= PASSCODE_RST;
      code_len_r  <= CODE_LEN_RST;
      arm_delay_r <= DELAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PASSCODE:  passcode_r  <= cfg_wdata[PASSCODE_W-1:0];
        REG_CODE_LEN:  code_len_r  <= cfg_wdata[CODE_LEN_W-1:0];
        REG_ARM_DELAY: arm_delay_r <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DISARMED;
      prev_key_r <= KEY_NONE;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      delay_r    <= '0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      prev_key_r <= key;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      delay_r    <= delay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_en) begin
      digits_r[count_r[IW-1:0]] <= prev_key_r[3:0] - 4'd1;
    end
  end

  // two-entry output queue
  assign in_tready  = (q_cnt_r != 2'd2);
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r[wr_ptr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (out_fire) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({in_fire, out_fire})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

endmodule

### hw/rtl/kapc_checker.sv
`timescale 1ns / 1ps
module kapc_checker
  import kapc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[2:0]))
    else $error("lamp pattern not one-hot");

  a_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == out_tdata[0]))
    else $error("buzzer differs from red lamp");

  a_tripped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:8] != 4'd0) |-> (out_tdata[6:4] == MODE_ALARM))
    else $error("tripped mask outside alarm mode");

  a_echo_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |->
      (out_tdata[6:4] == MODE_ARM_ENTRY) || (out_tdata[6:4] == MODE_DISARM_ENTRY))
    else $error("digit echo outside entry mode");

endmodule

bind keypad_alarm_panel_controller kapc_checker u_kapc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kapc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1050;
  localparam int unsigned MAX_WAIT       = 18;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SENSOR_W-1:0] sensors;
    logic                tick;
  } poll_t;

  typedef struct packed {
    logic                red;
    logic                green;
    logic                yellow;
    logic                buzzer;
    logic [2:0]          mode;
    logic                echo;
    logic [SENSOR_W-1:0] tripped;
  } panel_out_t;

  typedef enum logic [1:0] {
    ENTRY_RIGHT,
    ENTRY_BAD_DIGIT,
    ENTRY_BAD_LENGTH,
    ENTRY_OVERFLOW
  } entry_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_index = REG_PASSCODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // panel state mirror
  mode_t               panel_mode_q = MODE_DISARMED;
  logic [KEY_W-1:0]    last_key = KEY_NONE;
  logic [DIGIT_W-1:0]  code_buf [MAX_CODE_DIGITS_DEF];
  int unsigned         code_cnt = 0;
  logic                code_ovf = 1'b0;
  logic [DELAY_W-1:0]  delay_cnt = '0;
  logic [PASSCODE_W-1:0] pass_cfg = PASSCODE_RST;
  logic [CODE_LEN_W-1:0] len_cfg = CODE_LEN_RST;
  logic [DELAY_W-1:0]    delay_cfg = DELAY_RST;

  poll_t       poll_q [$];
  panel_out_t  status_q [$];
  poll_t       cur_poll;
  int unsigned item_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned out_hold = 0;
  int unsigned out_draw;
  int unsigned idle_cycles = 0;
  logic        in_no_gaps = 1'b0;
  logic        out_no_stall = 1'b0;

  keypad_alarm_panel_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_wait(input logic no_gaps);
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic code_matches();
    if (code_ovf || code_cnt != len_cfg) return 1'b0;
    for (int i = 0; i < code_cnt; i++) begin
      if (code_buf[i] != pass_cfg[4*i +: 4]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic panel_out_t panel_step(input poll_t p);
    panel_out_t       r;
    logic             rel;
    logic [KEY_W-1:0] rk;
    logic             done;
    logic             ok;
    rel = (p.key == KEY_NONE) && (last_key != KEY_NONE);
    rk = last_key;
    last_key = p.key;
    r = '0;
    done = 1'b0;
    if (rel && (panel_mode_q == MODE_ARM_ENTRY || panel_mode_q == MODE_DISARM_ENTRY)) begin
      if (rk == KEY_HASH) begin
        done = 1'b1;
      end else if (rk <= KEY_STAR) begin
        if (code_cnt < MAX_CODE_DIGITS_DEF) begin
          code_buf[code_cnt] = rk[3:0] - 4'd1;
          code_cnt++;
        end else begin
          code_ovf = 1'b1;
        end
        r.echo = 1'b1;
      end
    end
    case (panel_mode_q)
      MODE_DISARMED: begin
        if (rel && rk == KEY_STAR) begin
          code_cnt = 0;
          code_ovf = 1'b0;
          panel_mode_q = MODE_ARM_ENTRY;
        end
      end
      MODE_ARM_ENTRY: begin
        if (done) begin
          ok = code_matches();
          code_cnt = 0;
          code_ovf = 1'b0;
          if (ok) begin
            delay_cnt = '0;
            panel_mode_q = MODE_DELAY;
          end else begin
            panel_mode_q = MODE_WRONG;
          end
        end
      end
      MODE_DELAY: begin
        if (p.tick) begin
          delay_cnt = delay_cnt + 1'b1;
          if (delay_cnt >= delay_cfg) begin
            delay_cnt = '0;
            panel_mode_q = MODE_ARMED;
          end
        end
      end
      MODE_ARMED: begin
        if (p.sensors != '1) panel_mode_q = MODE_ALARM;
      end
      MODE_ALARM: begin
        if (rel && rk == KEY_HASH) begin
          code_cnt = 0;
          code_ovf = 1'b0;
          panel_mode_q = MODE_DISARM_ENTRY;
        end
      end
      MODE_DISARM_ENTRY: begin
        if (done) begin
          ok = code_matches();
          code_cnt = 0;
          code_ovf = 1'b0;
          if (ok) panel_mode_q = MODE_DISARMED;
        end
      end
      MODE_WRONG: begin
        if (rel && rk == KEY_HASH) begin
          code_cnt = 0;
          code_ovf = 1'b0;
          panel_mode_q = MODE_ARM_ENTRY;
        end
      end
      default: panel_mode_q = MODE_DISARMED;
    endcase
    r.red = (panel_mode_q == MODE_ALARM) || (panel_mode_q == MODE_DISARM_ENTRY);
    r.green = (panel_mode_q == MODE_DISARMED) || (panel_mode_q == MODE_ARM_ENTRY) ||
              (panel_mode_q == MODE_WRONG);
    r.yellow = (panel_mode_q == MODE_DELAY) || (panel_mode_q == MODE_ARMED);
    r.buzzer = r.red;
    r.mode = panel_mode_q;
    r.tripped = (panel_mode_q == MODE_ALARM) ? ~p.sensors : '0;
    return r;
  endfunction

  function automatic panel_out_t read_status(input logic [OUT_DATA_W-1:0] d);
    panel_out_t r;
    r.red = d[0];
    r.green = d[1];
    r.yellow = d[2];
    r.buzzer = d[3];
    r.mode = d[6:4];
    r.echo = d[7];
    r.tripped = d[11:8];
    return r;
  endfunction

  // input side: hold each beat until taken, then wait out the drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) status_q.push_back(panel_step(cur_poll));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (poll_q.size() != 0) begin
          cur_poll = poll_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W-10){1'b0}}, cur_poll.tick, cur_poll.sensors, cur_poll.key};
          gap_left <= draw_wait(in_no_gaps);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each beat, then stall for the drawn count
  always @(posedge clk) begin
    panel_out_t got;
    panel_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = read_status(out_tdata);
        if (status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result %h with nothing pending", $time, out_tdata);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: expected red %b green %b yellow %b buzzer %b mode %0d echo %b trip %h",
                       $time, want.red, want.green, want.yellow, want.buzzer, want.mode,
                       want.echo, want.tripped);
              $display("%0t:      got red %b green %b yellow %b buzzer %b mode %0d echo %b trip %h",
                       $time, got.red, got.green, got.yellow, got.buzzer, got.mode,
                       got.echo, got.tripped);
            end
          end
        end
        out_draw = draw_wait(out_no_stall);
        out_hold <= out_draw;
        out_tready <= (out_draw == 0);
      end else if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_tready <= (out_hold == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PASSCODE:  pass_cfg = val[PASSCODE_W-1:0];
      REG_CODE_LEN:  len_cfg = val[CODE_LEN_W-1:0];
      REG_ARM_DELAY: delay_cfg = val[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (poll_q.size() != 0 || in_tvalid || status_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic add_poll(input logic [KEY_W-1:0] k, input logic [SENSOR_W-1:0] s,
                          input logic t);
    poll_t p;
    p.key = k;
    p.sensors = s;
    p.tick = t;
    poll_q.push_back(p);
    item_cnt++;
  endtask

  function automatic logic [KEY_W-1:0] noise_key();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return KEY_W'(r + 1);
    return KEY_W'($urandom_range(17, 31));
  endfunction

  task automatic press(input logic [KEY_W-1:0] k);
    int unsigned hold;
    hold = $urandom_range(1, 3);
    repeat (hold) add_poll(k, SENSOR_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    add_poll(KEY_NONE, SENSOR_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [KEY_W-1:0] code_key(input int unsigned pos);
    if (pos >= MAX_CODE_DIGITS_DEF) return KEY_W'($urandom_range(1, 15));
    return {1'b0, pass_cfg[4*pos +: 4]} + 5'd1;
  endfunction

  task automatic enter_code(input entry_style_t style);
    int unsigned n;
    int unsigned bad_pos;
    logic [KEY_W-1:0] k;
    n = len_cfg;
    bad_pos = $urandom_range(0, 11);
    case (style)
      ENTRY_BAD_LENGTH: begin
        n = $urandom_range(0, MAX_CODE_DIGITS_DEF);
        if (n == len_cfg) n = (n + 1) % (MAX_CODE_DIGITS_DEF + 1);
      end
      ENTRY_OVERFLOW: n = $urandom_range(MAX_CODE_DIGITS_DEF + 1, MAX_CODE_DIGITS_DEF + 4);
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      k = code_key(i);
      if (style == ENTRY_BAD_DIGIT && i == bad_pos % n) begin
        k = KEY_W'($urandom_range(1, 15));
        if (k == code_key(i)) k = (k % 5'd15) + 5'd1;
      end
      press(k);
    end
    press(KEY_HASH);
  endtask

  task automatic retune();
    logic [PASSCODE_W-1:0] code;
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      code = '1;
    end else if (pick == 1) begin
      code = '0;
    end else begin
      for (int i = 0; i < 12; i++) code[4*i +: 4] = 4'($urandom_range(0, 14));
    end
    write_reg(REG_PASSCODE, code);
    pick = $urandom_range(0, 3);
    if (pick == 0) write_reg(REG_CODE_LEN, 48'd1);
    else if (pick == 1) write_reg(REG_CODE_LEN, 48'd12);
    else write_reg(REG_CODE_LEN, 48'($urandom_range(1, 12)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_ARM_DELAY, 48'd1);
    else write_reg(REG_ARM_DELAY, 48'($urandom_range(1, 10)));
  endtask

  // one step of the panel's normal use, chosen from the mirrored mode
  task automatic plan_segment();
    int unsigned ticks_left;
    int unsigned pick;
    logic t;
    pick = $urandom_range(0, 9);
    case (panel_mode_q)
      MODE_DISARMED: begin
        repeat ($urandom_range(0, 2)) press(noise_key());
        press(KEY_STAR);
      end
      MODE_ARM_ENTRY, MODE_DISARM_ENTRY: begin
        if (pick < 6) enter_code(ENTRY_RIGHT);
        else if (pick == 6) enter_code(ENTRY_BAD_DIGIT);
        else if (pick < 9) enter_code(ENTRY_BAD_LENGTH);
        else enter_code(ENTRY_OVERFLOW);
      end
      MODE_DELAY: begin
        ticks_left = (delay_cnt < delay_cfg) ? delay_cfg - delay_cnt : 1;
        while (ticks_left != 0) begin
          t = ($urandom_range(0, 3) != 0);
          add_poll(($urandom_range(0, 5) == 0) ? noise_key() : KEY_NONE,
                   SENSOR_W'($urandom_range(0, 15)), t);
          if (t) ticks_left--;
        end
      end
      MODE_ARMED: begin
        repeat ($urandom_range(0, 4))
          add_poll(($urandom_range(0, 1) == 0) ? noise_key() : KEY_NONE, '1,
                   1'($urandom_range(0, 1)));
        add_poll(KEY_NONE, SENSOR_W'($urandom_range(0, 14)), 1'($urandom_range(0, 1)));
      end
      MODE_ALARM: begin
        repeat ($urandom_range(0, 3))
          add_poll(KEY_NONE, SENSOR_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        if (pick == 0) press(noise_key());
        press(KEY_HASH);
      end
      MODE_WRONG: begin
        repeat ($urandom_range(0, 2)) press(noise_key());
        press(KEY_HASH);
      end
      default: add_poll(KEY_NONE, '1, 1'b0);
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // two-digit code: '0' then star as a code key
    write_reg(REG_PASSCODE, 48'h0000_0000_00E0);
    write_reg(REG_CODE_LEN, 48'd2);
    write_reg(REG_ARM_DELAY, 48'd65535);
    @(negedge clk);
    add_poll(KEY_HASH, 4'h0, 1'b1);
    add_poll(KEY_NONE, 4'h0, 1'b0);
    add_poll(5'd31, 4'hF, 1'b1);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_STAR, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b1);
    add_poll(5'd1, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_HASH, 4'hF, 1'b1);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_HASH, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b1);
    add_poll(5'd1, 4'h5, 1'b0);
    add_poll(KEY_NONE, 4'hA, 1'b0);
    add_poll(KEY_STAR, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_HASH, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b1);
    add_poll(KEY_NONE, 4'h0, 1'b1);
    add_poll(KEY_NONE, 4'h3, 1'b1);
    // shorten the delay below the count already reached
    wait_idle();
    write_reg(REG_ARM_DELAY, 48'd1);
    @(negedge clk);
    add_poll(KEY_NONE, 4'hF, 1'b1);
    add_poll(KEY_HASH, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hE, 1'b1);
    add_poll(KEY_HASH, 4'h0, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(5'd1, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_STAR, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    add_poll(KEY_HASH, 4'hF, 1'b0);
    add_poll(KEY_NONE, 4'hF, 1'b0);
    while (item_cnt < RANDOM_ITEMS + 31) begin
      wait_idle();
      if ($urandom_range(0, 7) == 0) retune();
      in_no_gaps = ($urandom_range(0, 4) == 0);
      out_no_stall = ($urandom_range(0, 4) == 0);
      @(negedge clk);
      plan_segment();
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
